// ===== rtl/core/st2s_pkg.sv =====
// Shared types, sizes and key compare for the stable two-key record sorter.
package st2s_pkg;

    // Number of cells in the insertion chain, which is the record capacity.
    localparam int MAX_RECORDS = 64;

    localparam int TAG_W   = 16;
    localparam int LAYER_W = 16;
    localparam int POS_W   = 24;

    // One stored record.
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [LAYER_W-1:0] layer;
        logic [POS_W-1:0]   pos;
    } t_rec;

    // Control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctrl;

    // True when record a must come strictly after record b.
    function automatic logic key_gt(input t_rec a, input t_rec b);
        logic gt;
        if (a.layer != b.layer) begin
            gt = ($signed(a.layer) > $signed(b.layer));
        end else begin
            gt = ($signed(a.pos) > $signed(b.pos));
        end
        return gt;
    endfunction

endpackage

// ===== rtl/core/stable_two_key_record_sort_core.sv =====
// Top level of the stable two-key record sorter: cell chain and drain control.
//
// Records enter one per cycle while busy is low: each accepted request is placed
// into its sorted slot in the same cycle by a chain of MAX_RECORDS cells that all
// compare against the new record at once. A request with is_last raises busy,
// which stays high until all stored records have come out, while the chain shifts
// toward cell zero and puts out one sorted record per cycle on o_valid; o_out_last
// marks the final one. The receiver cannot stall, so each result is valid for
// exactly one cycle. Order is depth layer ascending, then vertical position
// ascending, with ties kept in arrival order. Records arriving on a full chain
// are dropped, and o_overflowed is then high on every result of that run. After
// the drain the chain is empty.
module stable_two_key_record_sort_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_record_tag,
    input  logic signed [15:0] i_depth_layer,
    input  logic signed [23:0] i_vertical_pos,
    input  logic        i_is_last,
    output logic        o_valid,
    output logic [15:0] o_out_tag,
    output logic signed [15:0] o_out_layer,
    output logic signed [23:0] o_out_pos,
    output logic        o_out_last,
    output logic        o_overflowed
);

    localparam int N = st2s_pkg::MAX_RECORDS;

    st2s_pkg::t_rec       new_rec;
    st2s_pkg::t_cell_ctrl ctrl;
    st2s_pkg::t_rec       cell_rec   [N];
    logic [N-1:0]         cell_valid;
    logic [N-1:0]         cell_moves;
    logic                 accept;
    logic                 full;
    logic                 r_drain;
    logic                 n_drain;
    logic                 r_dropped;
    logic                 n_dropped;
    logic                 drain_end;

    assign new_rec.tag   = i_record_tag;
    assign new_rec.layer = i_depth_layer;
    assign new_rec.pos   = i_vertical_pos;

    assign accept    = start && !r_drain;
    assign full      = cell_valid[N-1];
    assign drain_end = r_drain && !cell_valid[1];

    assign ctrl.insert    = accept && !full;
    assign ctrl.shift_out = r_drain;

    // The chain of cells; cell zero is the head of the sorted order.
    for (genvar g = 0; g < N; g++) begin : g_cell
        st2s_pkg::t_rec left_rec;
        st2s_pkg::t_rec right_rec;
        logic           left_valid;
        logic           left_moves;
        logic           right_valid;

        if (g == 0) begin : g_head
            assign left_rec   = new_rec;
            assign left_valid = 1'b0;
            assign left_moves = 1'b0;
        end else begin : g_mid
            assign left_rec   = cell_rec[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_moves = cell_moves[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign right_rec   = new_rec;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_rec   = cell_rec[g+1];
            assign right_valid = cell_valid[g+1];
        end

        st2s_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_new_rec     (new_rec),
            .i_left_rec    (left_rec),
            .i_left_valid  (left_valid),
            .i_left_moves  (left_moves),
            .i_right_rec   (right_rec),
            .i_right_valid (right_valid),
            .o_rec         (cell_rec[g]),
            .o_valid       (cell_valid[g]),
            .o_moves       (cell_moves[g])
        );
    end

    // Drain and overflow control.
    always_comb begin
        n_drain   = r_drain;
        n_dropped = r_dropped;
        if (accept) begin
            if (full) begin
                n_dropped = 1'b1;
            end
            if (i_is_last) begin
                n_drain = 1'b1;
            end
        end else if (drain_end) begin
            n_drain   = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_drain   <= n_drain;
            r_dropped <= n_dropped;
        end
    end

    // Results come straight from the head cell while draining.
    assign busy         = r_drain;
    assign o_valid      = r_drain;
    assign o_out_tag    = cell_rec[0].tag;
    assign o_out_layer  = cell_rec[0].layer;
    assign o_out_pos    = cell_rec[0].pos;
    assign o_out_last   = drain_end;
    assign o_overflowed = r_dropped;

endmodule

// ===== rtl/core/st2s_cell.sv =====
// One cell of the sorting chain: holds a record and hands it to a neighbor.
module st2s_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  st2s_pkg::t_cell_ctrl  i_ctrl,
    input  st2s_pkg::t_rec        i_new_rec,
    input  st2s_pkg::t_rec        i_left_rec,
    input  logic                  i_left_valid,
    input  logic                  i_left_moves,
    input  st2s_pkg::t_rec        i_right_rec,
    input  logic                  i_right_valid,
    output st2s_pkg::t_rec        o_rec,
    output logic                  o_valid,
    output logic                  o_moves
);

    st2s_pkg::t_rec r_rec;
    st2s_pkg::t_rec n_rec;
    logic           r_valid;
    logic           n_valid;

    // An empty cell, or one holding a strictly later key, makes room.
    assign o_moves = !r_valid || st2s_pkg::key_gt(r_rec, i_new_rec);

    // Next contents: shift right on insert, shift left while draining.
    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctrl.insert && o_moves) begin
            if (i_left_moves) begin
                n_rec   = i_left_rec;
                n_valid = i_left_valid;
            end else begin
                n_rec   = i_new_rec;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.shift_out) begin
            n_rec   = i_right_rec;
            n_valid = i_right_valid;
        end
    end

    // Valid bit is control state; the record itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;

endmodule

// ===== verif/tb_stable_two_key_record_sort_core.sv =====
// Self-checking testbench for the stable two-key record sort core.
`timescale 1ns / 100ps

module tb_stable_two_key_record_sort_core;

    // One sorted record as it leaves the block.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] layer;
        logic [23:0] pos;
        logic        last;
        logic        ovf;
    } t_drain_rec;

    // One directed request; has_exp marks rows whose result is typed in.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] layer;
        logic [23:0] pos;
        logic        last;
        logic        has_exp;
        t_drain_rec  exp;
    } t_stim_row;

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 300;

    // Single-record sets carry their own result; the rest go through the sorter.
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{16'hFFFF, 16'h7FFF, 24'h7FFFFF, 1'b1, 1'b1,
          '{16'hFFFF, 16'h7FFF, 24'h7FFFFF, 1'b1, 1'b0}},
        '{16'h0000, 16'h8000, 24'h800000, 1'b1, 1'b1,
          '{16'h0000, 16'h8000, 24'h800000, 1'b1, 1'b0}},
        '{16'hA5A5, 16'h0000, 24'h000000, 1'b1, 1'b1,
          '{16'hA5A5, 16'h0000, 24'h000000, 1'b1, 1'b0}},
        // Mixed layers, a tie on both keys, and both extremes of each key.
        '{16'h0001, 16'h7FFF, 24'h000000, 1'b0, 1'b0, '0},
        '{16'h0002, 16'h8000, 24'h000000, 1'b0, 1'b0, '0},
        '{16'h0003, 16'h0000, 24'h000100, 1'b0, 1'b0, '0},
        '{16'h0004, 16'h0000, 24'hFFFF00, 1'b0, 1'b0, '0},
        '{16'h0005, 16'h0000, 24'h000100, 1'b0, 1'b0, '0},
        '{16'h0006, 16'h8000, 24'h7FFFFF, 1'b0, 1'b0, '0},
        '{16'h0007, 16'h8000, 24'h800000, 1'b1, 1'b0, '0},
        // All keys equal: arrival order must survive.
        '{16'h0010, 16'h0005, 24'h000005, 1'b0, 1'b0, '0},
        '{16'h0011, 16'h0005, 24'h000005, 1'b0, 1'b0, '0},
        '{16'h0012, 16'h0005, 24'h000005, 1'b0, 1'b0, '0},
        '{16'h0013, 16'h0005, 24'h000005, 1'b0, 1'b0, '0},
        '{16'h0014, 16'h0005, 24'h000005, 1'b1, 1'b0, '0},
        // Strictly descending layers arrive, ascending must leave.
        '{16'h0020, 16'h0003, 24'h000000, 1'b0, 1'b0, '0},
        '{16'h0021, 16'h0002, 24'h000000, 1'b0, 1'b0, '0},
        '{16'h0022, 16'h0001, 24'h000000, 1'b0, 1'b0, '0},
        '{16'h0023, 16'h0000, 24'h000000, 1'b1, 1'b0, '0},
        '{16'h5A5A, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1,
          '{16'h5A5A, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0}}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [15:0] i_record_tag   = '0;
    logic [15:0] i_depth_layer  = '0;
    logic [23:0] i_vertical_pos = '0;
    logic        i_is_last      = 1'b0;
    logic        o_valid;
    logic [15:0] o_out_tag;
    logic [15:0] o_out_layer;
    logic [23:0] o_out_pos;
    logic        o_out_last;
    logic        o_overflowed;

    // Shadow copy of the sorted store and the expected drain output.
    st2s_pkg::t_rec shadow_store [$];
    bit             shadow_dropped = 1'b0;
    t_drain_rec     sorted_out_q [$];
    int             mismatches     = 0;
    bit             no_idle        = 1'b0;

    stable_two_key_record_sort_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_record_tag   (i_record_tag),
        .i_depth_layer  (i_depth_layer),
        .i_vertical_pos (i_vertical_pos),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .o_out_tag      (o_out_tag),
        .o_out_layer    (o_out_layer),
        .o_out_pos      (o_out_pos),
        .o_out_last     (o_out_last),
        .o_overflowed   (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    // True when record a sorts strictly after record b: layer first, then position.
    function automatic bit comes_after(input st2s_pkg::t_rec a, input st2s_pkg::t_rec b);
        if (a.layer != b.layer) begin
            return $signed(a.layer) > $signed(b.layer);
        end
        return $signed(a.pos) > $signed(b.pos);
    endfunction

    // Insert one accepted request into the shadow store and, on the last one, queue
    // the whole sorted run if keep is set, and empty the store.
    function automatic void sorter_accept(input st2s_pkg::t_rec rec, input bit last,
                                          input bit keep);
        int         p;
        t_drain_rec r;
        if (shadow_store.size() >= st2s_pkg::MAX_RECORDS) begin
            shadow_dropped = 1'b1;
        end else begin
            p = 0;
            while (p < shadow_store.size() && !comes_after(shadow_store[p], rec)) begin
                p++;
            end
            shadow_store.insert(p, rec);
        end
        if (last) begin
            foreach (shadow_store[i]) begin
                r.tag   = shadow_store[i].tag;
                r.layer = shadow_store[i].layer;
                r.pos   = shadow_store[i].pos;
                r.last  = (i == shadow_store.size() - 1);
                r.ovf   = shadow_dropped;
                if (keep) begin
                    sorted_out_q.push_back(r);
                end
            end
            shadow_store.delete();
            shadow_dropped = 1'b0;
        end
    endfunction

    // Keys drawn from a narrow range half of the time so ties are common, with
    // full-range and extreme values mixed in.
    function automatic st2s_pkg::t_rec random_record();
        st2s_pkg::t_rec r;
        int             v;
        r.tag = 16'($urandom);
        v = int'($urandom_range(4)) - 2;
        case ($urandom_range(3))
            0:       r.layer = 16'($urandom);
            3:       r.layer = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: r.layer = v[15:0];
        endcase
        v = int'($urandom_range(4)) - 2;
        case ($urandom_range(3))
            0:       r.pos = 24'($urandom);
            3:       r.pos = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
            default: r.pos = v[23:0];
        endcase
        return r;
    endfunction

    // Present one request at the falling edge and hold it until it is taken.
    task automatic send_record(input st2s_pkg::t_rec rec, input bit last);
        @(negedge i_clk);
        start          = 1'b1;
        i_record_tag   = rec.tag;
        i_depth_layer  = rec.layer;
        i_vertical_pos = rec.pos;
        i_is_last      = last;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // Random sender gap, with junk on the data ports while start is low.
    task automatic idle_gap();
        int k;
        if (!no_idle && $urandom_range(99) < 23) begin
            k = $urandom_range(1, 4);
            @(negedge i_clk);
            start          = 1'b0;
            i_record_tag   = 16'($urandom);
            i_depth_layer  = 16'($urandom);
            i_vertical_pos = 24'($urandom);
            i_is_last      = 1'($urandom);
            repeat (k - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every queued result has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (sorted_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (st2s_pkg::MAX_RECORDS + 4) @(posedge i_clk);
    endtask

    // Compare every strobed result with the oldest expected one.
    always @(posedge i_clk) begin
        t_drain_rec got;
        t_drain_rec want;
        if (i_rst_n && o_valid === 1'b1) begin
            got = '{o_out_tag, o_out_layer, o_out_pos, o_out_last, o_overflowed};
            if (sorted_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: tag=%h layer=%h pos=%h last=%b ovf=%b",
                             got.tag, got.layer, got.pos, got.last, got.ovf);
                end
            end else begin
                want = sorted_out_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch at %0t:", $realtime);
                        $display("  expected tag=%h layer=%h pos=%h last=%b ovf=%b",
                                 want.tag, want.layer, want.pos, want.last, want.ovf);
                        $display("  actual   tag=%h layer=%h pos=%h last=%b ovf=%b",
                                 got.tag, got.layer, got.pos, got.last, got.ovf);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random sets of records.
    initial begin
        st2s_pkg::t_rec rec;
        int             set_len;
        int             set_no;
        int             rnd_sent;
        bit             last;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            rec.tag   = DIRECTED[i].tag;
            rec.layer = DIRECTED[i].layer;
            rec.pos   = DIRECTED[i].pos;
            idle_gap();
            send_record(rec, DIRECTED[i].last);
            if (DIRECTED[i].has_exp) begin
                sorter_accept(rec, DIRECTED[i].last, 1'b0);
                sorted_out_q.push_back(DIRECTED[i].exp);
            end else begin
                sorter_accept(rec, DIRECTED[i].last, 1'b1);
            end
        end
        wait_drained();

        // First an overflowing set closed on a full store, then an exactly full one,
        // then mostly short sets with an occasional one near capacity.
        rnd_sent = 0;
        set_no   = 0;
        while (rnd_sent < N_RANDOM) begin
            if (set_no == 0) begin
                set_len = 68;
            end else if (set_no == 1) begin
                set_len = st2s_pkg::MAX_RECORDS;
            end else if ($urandom_range(9) == 0) begin
                set_len = $urandom_range(60, 72);
            end else begin
                set_len = $urandom_range(1, 12);
            end
            // The final set is cut short so the total stays on budget.
            if (set_len > N_RANDOM - rnd_sent) begin
                set_len = N_RANDOM - rnd_sent;
            end
            if (set_no == 6) begin
                wait_drained();
            end
            for (int k = 0; k < set_len; k++) begin
                no_idle = (rnd_sent >= 150 && rnd_sent < 230);
                rec     = random_record();
                last    = (k == set_len - 1);
                idle_gap();
                send_record(rec, last);
                sorter_accept(rec, last, 1'b1);
                rnd_sent++;
            end
            set_no++;
        end
        wait_drained();

        if (mismatches == 0) begin
            $display("stable_two_key_record_sort_core: match");
        end else begin
            $display("stable_two_key_record_sort_core: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake or missing results.
    initial begin
        #2000000;
        $display("stable_two_key_record_sort_core: mismatch");
        $finish;
    end

endmodule
